// File: src/lr_pkg.sv
// Shared types and constants for the line rasterizer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package lr_pkg;

    // Coordinate and color widths of the stream fields, plus default coordinate bits and queue depth
    localparam int COORD_W      = 6;
    localparam int COLOR_W      = 24;
    localparam int COORD_BITS_D = 6;
    localparam int QUEUE_DEPTH  = 2;

    localparam int S_TDATA_W = 4 * COORD_W + COLOR_W;          // 48
    localparam int M_FIELD_W = 2 * COORD_W + COLOR_W;          // 36
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;      // 40

    // Classified line command handed from front to back
    typedef struct packed {
        logic               xmajor;
        logic               dir_neg;
        logic [COORD_W-1:0] maj0;
        logic [COORD_W-1:0] maj1;
        logic [COORD_W-1:0] min0;
        logic [COORD_W-1:0] dmaj;
        logic [COORD_W-1:0] dmin;
        logic [COLOR_W-1:0] color;
    } line_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DRAW = 2'b10
    } draw_state_t;

endpackage

`default_nettype wire

// File: src/lr_front.sv
// Front end: unpacks a line command, picks the major axis, orders the
// endpoints and derives deltas and minor direction. Depends on lr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lr_front
    import lr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_D
) (
    input  wire logic [S_TDATA_W-1:0] cmd_data,
    output line_cmd_t                 cmd_out
);

    localparam logic [COORD_W-1:0] MASK =
        COORD_W'((7'd1 << COORD_BITS) - 7'd1);

    logic [COORD_W-1:0] ax, ay, bx, by;
    logic [COORD_W-1:0] adx, ady;
    logic [COORD_W-1:0] pmaj0, pmaj1, pmin0, pmin1;
    logic [COORD_W-1:0] maj0, maj1, min0, min1;
    logic               xmajor;

    always_comb begin
        ax = cmd_data[COORD_W-1:0] & MASK;
        ay = cmd_data[2*COORD_W-1:COORD_W] & MASK;
        bx = cmd_data[3*COORD_W-1:2*COORD_W] & MASK;
        by = cmd_data[4*COORD_W-1:3*COORD_W] & MASK;

        adx = (ax > bx) ? ax - bx : bx - ax;
        ady = (ay > by) ? ay - by : by - ay;
        xmajor = adx > ady;   // ties go to y

        if (xmajor) begin
            pmaj0 = ax; pmaj1 = bx; pmin0 = ay; pmin1 = by;
        end else begin
            pmaj0 = ay; pmaj1 = by; pmin0 = ax; pmin1 = bx;
        end

        if (pmaj0 > pmaj1) begin
            maj0 = pmaj1; maj1 = pmaj0; min0 = pmin1; min1 = pmin0;
        end else begin
            maj0 = pmaj0; maj1 = pmaj1; min0 = pmin0; min1 = pmin1;
        end

        cmd_out.xmajor  = xmajor;
        cmd_out.maj0    = maj0;
        cmd_out.maj1    = maj1;
        cmd_out.min0    = min0;
        cmd_out.dmaj    = maj1 - maj0;
        cmd_out.dir_neg = min1 < min0;
        cmd_out.dmin    = (min1 < min0) ? min0 - min1 : min1 - min0;
        cmd_out.color   = cmd_data[S_TDATA_W-1:4*COORD_W];
    end

endmodule

`default_nettype wire

// File: src/lr_cmd_fifo.sv
// Short queue of classified line commands between front and back.
// Depends on lr_pkg for line_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module lr_cmd_fifo
    import lr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      wr_en,
    input  line_cmd_t      wr_data,
    output logic           full,
    input  wire logic      rd_en,
    output line_cmd_t      rd_data,
    output logic           not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    line_cmd_t          slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_wr, do_rd;

    assign full      = count_reg == CNT_W'(DEPTH);
    assign not_empty = count_reg != '0;
    assign do_wr     = wr_en && !full;
    assign do_rd     = rd_en && not_empty;
    assign rd_data   = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// File: src/lr_back.sv
// Back end: Bresenham stepper, one pixel per cycle into an output register while the receiver accepts.
// Depends on lr_pkg for line_cmd_t and draw_state_t.
`timescale 1ns / 1ps
`default_nettype none

module lr_back
    import lr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_D
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  line_cmd_t                 cmd,
    input  wire logic                 cmd_valid,
    output logic                      cmd_pop,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic                      m_tlast
);

    // accumulator stays at or below dmaj + dmin
    localparam int ERR_W = COORD_BITS + 1;

    draw_state_t        state_reg, state_next;
    logic               m_valid_reg, m_valid_next;
    logic               xmajor_reg, dir_neg_reg;
    logic [COORD_W-1:0] major_reg, maj1_reg, minor_reg, dmaj_reg, dmin_reg;
    logic [ERR_W-1:0]   err_reg, err_bump;
    logic [COLOR_W-1:0] color_reg;
    logic [COORD_W-1:0] px_reg, py_reg;
    logic [COLOR_W-1:0] pcolor_reg;
    logic               plast_reg;
    logic               step, at_end, minor_move;

    assign cmd_pop    = (state_reg == ST_IDLE) && cmd_valid;
    assign step       = (state_reg == ST_DRAW) && (!m_valid_reg || m_tready);
    assign at_end     = major_reg == maj1_reg;
    assign minor_move = err_reg > ERR_W'(dmaj_reg);
    assign err_bump   = minor_move ? err_reg - ERR_W'(dmaj_reg) + ERR_W'(dmin_reg)
                                   : err_reg + ERR_W'(dmin_reg);

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    state_next = ST_DRAW;
                end
            end
            ST_DRAW: begin
                if (step) begin
                    m_valid_next = 1'b1;
                    if (at_end) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_pop) begin
            xmajor_reg  <= cmd.xmajor;
            dir_neg_reg <= cmd.dir_neg;
            major_reg   <= cmd.maj0;
            maj1_reg    <= cmd.maj1;
            minor_reg   <= cmd.min0;
            dmaj_reg    <= cmd.dmaj;
            dmin_reg    <= cmd.dmin;
            color_reg   <= cmd.color;
            err_reg     <= '0;
        end else if (step) begin
            px_reg     <= xmajor_reg ? major_reg : minor_reg;
            py_reg     <= xmajor_reg ? minor_reg : major_reg;
            pcolor_reg <= color_reg;
            plast_reg  <= at_end;
            major_reg  <= major_reg + 1'b1;
            err_reg    <= err_bump;
            // minor wraps modulo 64 like the six-bit output field
            if (minor_move) begin
                minor_reg <= dir_neg_reg ? minor_reg - 1'b1 : minor_reg + 1'b1;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = plast_reg;
    assign m_tdata  = {(M_TDATA_W - M_FIELD_W)'(0), pcolor_reg, py_reg, px_reg};

    a_load_clears_err: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_pop |=> (err_reg == '0) && (state_reg == ST_DRAW))
        else $error("accumulator not cleared on line load");

    a_err_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAW) |->
            ({1'b0, err_reg} <= ({2'b0, dmaj_reg} + {2'b0, dmin_reg})))
        else $error("error accumulator out of range");

    a_last_ends_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && at_end) |=> (state_reg == ST_IDLE) && m_tvalid && m_tlast)
        else $error("final pixel did not end the line");

    a_pixel_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_DRAW))
        else $error("pixel emitted outside of drawing");

endmodule

`default_nettype wire

// File: src/line_rasterizer_core.sv
// Path: a command is written into the queue at acceptance, loaded by the stepper
// from ST_IDLE once the previous line is done, and its first pixel is then registered onto m_tvalid.
// The stepper gives one pixel per cycle while the receiver accepts, and a line
// has (major delta + 1) pixels: up to 64 per command.
// Reset clears the queue count and pointers, the stepper state and m_tvalid.
// Top level of the line rasterizer; depends on lr_pkg, lr_front, lr_cmd_fifo, lr_back.
`timescale 1ns / 1ps
`default_nettype none

module line_rasterizer_core
    import lr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_D,
    parameter int DEPTH      = QUEUE_DEPTH
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // start_x[5:0], start_y[11:6], end_x[17:12], end_y[23:18], line_color[47:24]
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // pixel_x[5:0], pixel_y[11:6], pixel_color[35:12], zero pad [39:36]
    output logic [M_TDATA_W-1:0]      m_tdata,
    // last_pixel
    output logic                      m_tlast
);

    line_cmd_t front_cmd, queued_cmd;
    logic      q_full, q_valid, q_pop;

    assign s_tready = !q_full;

    lr_front #(.COORD_BITS(COORD_BITS)) u_front (
        .cmd_data (s_tdata),
        .cmd_out  (front_cmd)
    );

    lr_cmd_fifo #(.DEPTH(DEPTH)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (s_tvalid),
        .wr_data   (front_cmd),
        .full      (q_full),
        .rd_en     (q_pop),
        .rd_data   (queued_cmd),
        .not_empty (q_valid)
    );

    lr_back #(.COORD_BITS(COORD_BITS)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (queued_cmd),
        .cmd_valid (q_valid),
        .cmd_pop   (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

// File: bench/line_rasterizer_core_test.sv
// Self-checking bench for line_rasterizer_core: drives line commands and checks every pixel against the expected list.
// Depends on lr_pkg and the line_rasterizer_core RTL only.
`timescale 1ns / 1ps

module line_rasterizer_core_test;
    import lr_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_CYCLES = 80;
    localparam int LONG_HOLD = 400;
    localparam int N_DIRECTED = 20;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COLOR_W-1:0] color;
        logic               last;
    } pixel_t;

    // has_pix rows carry their single pixel typed in; the rest go through the predictor
    typedef struct packed {
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        logic [COORD_W-1:0] ex;
        logic [COORD_W-1:0] ey;
        logic [COLOR_W-1:0] color;
        logic               has_pix;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
    } line_row_t;

    localparam line_row_t LINE_ROWS [N_DIRECTED] = '{
        '{6'd0,  6'd0,  6'd0,  6'd0,  24'h000000, 1'b1, 6'd0,  6'd0},   // single point
        '{6'd63, 6'd63, 6'd63, 6'd63, 24'hFFFFFF, 1'b1, 6'd63, 6'd63},
        '{6'd21, 6'd42, 6'd21, 6'd42, 24'hA5A5A5, 1'b1, 6'd21, 6'd42},
        '{6'd0,  6'd0,  6'd63, 6'd0,  24'hFF0000, 1'b0, 6'd0,  6'd0},   // full width
        '{6'd63, 6'd63, 6'd0,  6'd63, 24'h00FF00, 1'b0, 6'd0,  6'd0},
        '{6'd0,  6'd0,  6'd0,  6'd63, 24'h0000FF, 1'b0, 6'd0,  6'd0},   // full height
        '{6'd63, 6'd63, 6'd63, 6'd0,  24'hAAAAAA, 1'b0, 6'd0,  6'd0},
        '{6'd0,  6'd0,  6'd63, 6'd63, 24'h555555, 1'b0, 6'd0,  6'd0},   // tie: y major
        '{6'd63, 6'd0,  6'd0,  6'd63, 24'h123456, 1'b0, 6'd0,  6'd0},
        '{6'd2,  6'd3,  6'd40, 6'd17, 24'hABCDEF, 1'b0, 6'd0,  6'd0},
        '{6'd5,  6'd30, 6'd50, 6'd4,  24'hFEDCBA, 1'b0, 6'd0,  6'd0},   // minor falls
        '{6'd50, 6'd60, 6'd30, 6'd2,  24'h0F0F0F, 1'b0, 6'd0,  6'd0},
        '{6'd10, 6'd2,  6'd40, 6'd60, 24'hF0F0F0, 1'b0, 6'd0,  6'd0},
        '{6'd40, 6'd2,  6'd10, 6'd60, 24'hC3C3C3, 1'b0, 6'd0,  6'd0},   // steep, x goes down
        '{6'd0,  6'd10, 6'd20, 6'd9,  24'h777777, 1'b0, 6'd0,  6'd0},
        '{6'd0,  6'd0,  6'd1,  6'd1,  24'h888888, 1'b0, 6'd0,  6'd0},
        '{6'd0,  6'd0,  6'd2,  6'd1,  24'h010101, 1'b0, 6'd0,  6'd0},
        '{6'd63, 6'd0,  6'd0,  6'd1,  24'h808080, 1'b0, 6'd0,  6'd0},
        '{6'd3,  6'd0,  6'd4,  6'd63, 24'h7F7F7F, 1'b0, 6'd0,  6'd0},
        '{6'd33, 6'd17, 6'd34, 6'd17, 24'hFFFF00, 1'b0, 6'd0,  6'd0}
    };

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    pixel_t pixels_due[$];
    int     fail_cnt = 0;
    int     src_idle_pct = 0;
    int     sink_idle_pct = 0;
    int     sink_hold = 0;
    int     cycle_cnt = 0;

    line_rasterizer_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [S_TDATA_W-1:0] pack_line(
        input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
        input logic [COORD_W-1:0] ex, input logic [COORD_W-1:0] ey,
        input logic [COLOR_W-1:0] color);
        return {color, ey, ex, sy, sx};
    endfunction

    // Bresenham walk along the major axis; minor steps toward the far endpoint
    function automatic void trace_line(input logic [S_TDATA_W-1:0] cmd);
        int     ax, ay, bx, by, adx, ady;
        int     maj0, maj1, min0, min1, dmaj, dmin, dir, err, minor, t;
        bit     xmajor;
        pixel_t p;
        ax = cmd[5:0];
        ay = cmd[11:6];
        bx = cmd[17:12];
        by = cmd[23:18];
        adx = (ax > bx) ? ax - bx : bx - ax;
        ady = (ay > by) ? ay - by : by - ay;
        xmajor = adx > ady;
        if (xmajor) begin
            maj0 = ax; maj1 = bx; min0 = ay; min1 = by;
        end else begin
            maj0 = ay; maj1 = by; min0 = ax; min1 = bx;
        end
        if (maj0 > maj1) begin
            t = maj0; maj0 = maj1; maj1 = t;
            t = min0; min0 = min1; min1 = t;
        end
        dmaj = maj1 - maj0;
        dmin = min1 - min0;
        dir = 1;
        if (dmin < 0) begin
            dir = -1;
            dmin = -dmin;
        end
        err = 0;
        minor = min0;
        for (int major = maj0; major <= maj1; major++) begin
            p.x = xmajor ? 6'(major) : 6'(minor);
            p.y = xmajor ? 6'(minor) : 6'(major);
            p.color = cmd[47:24];
            p.last = (major == maj1);
            pixels_due = {pixels_due, p};
            if (err > dmaj) begin
                minor += dir;
                err -= dmaj;
            end
            err += dmin;
        end
    endfunction

    function automatic logic [S_TDATA_W-1:0] random_line();
        int sx, sy, ex, ey, kind;
        kind = $urandom_range(0, 99);
        sx = $urandom_range(0, 63);
        sy = $urandom_range(0, 63);
        if (kind < 60) begin
            ex = $urandom_range(0, 63);
            ey = $urandom_range(0, 63);
        end else if (kind < 92) begin
            // short lines near the start point, clipped to the canvas
            ex = sx + $urandom_range(0, 8) - 4;
            ey = sy + $urandom_range(0, 8) - 4;
            ex = (ex < 0) ? 0 : (ex > 63) ? 63 : ex;
            ey = (ey < 0) ? 0 : (ey > 63) ? 63 : ey;
        end else begin
            ex = sx;
            ey = sy;
        end
        return pack_line(6'(sx), 6'(sy), 6'(ex), 6'(ey), 24'($urandom()));
    endfunction

    // Offer one command; the item is taken at the edge after a negedge with s_tready high
    task automatic offer_line(input logic [S_TDATA_W-1:0] cmd, input bit predict,
                              input pixel_t typed);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= cmd;
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        @(posedge aclk);
        if (predict) trace_line(cmd);
        else pixels_due = {pixels_due, typed};
    endtask

    task automatic run_random(input int count);
        pixel_t none;
        none = '0;
        repeat (count) offer_line(random_line(), 1'b1, none);
    endtask

    task automatic log_failure(input string msg);
        fail_cnt++;
        if (fail_cnt <= 10) $display("%s", msg);
    endtask

    // Receiver: random ready, plus one long hold-off set by the main sequence and counted down here
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (sink_hold > 0) begin
                sink_hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    // Values sampled mid-cycle are the ones seen at the next rising edge
    always @(negedge aclk) begin : check_pixels
        pixel_t want;
        pixel_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.x = m_tdata[5:0];
            got.y = m_tdata[11:6];
            got.color = m_tdata[35:12];
            got.last = m_tlast;
            if (pixels_due.size() == 0) begin
                log_failure($sformatf("unexpected pixel x=%0d y=%0d color=%06h last=%0b",
                                      got.x, got.y, got.color, got.last));
            end else begin
                want = pixels_due.pop_front();
                if (got !== want)
                    log_failure($sformatf({"pixel mismatch: exp x=%0d y=%0d color=%06h ",
                                           "last=%0b, got x=%0d y=%0d color=%06h last=%0b"},
                                          want.x, want.y, want.color, want.last,
                                          got.x, got.y, got.color, got.last));
            end
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("line_rasterizer_core verification failed");
        $finish;
    end

    initial begin
        pixel_t typed;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // slow receiver
        src_idle_pct  = 22;
        sink_idle_pct = 78;
        for (int i = 0; i < N_DIRECTED; i++) begin
            typed.x = LINE_ROWS[i].px;
            typed.y = LINE_ROWS[i].py;
            typed.color = LINE_ROWS[i].color;
            typed.last = 1'b1;
            offer_line(pack_line(LINE_ROWS[i].sx, LINE_ROWS[i].sy, LINE_ROWS[i].ex,
                                 LINE_ROWS[i].ey, LINE_ROWS[i].color),
                       !LINE_ROWS[i].has_pix, typed);
        end
        run_random(130);

        // sender holds back until the block has drained
        s_tvalid <= 1'b0;
        while (pixels_due.size() != 0) @(posedge aclk);

        // slow sender
        src_idle_pct  = 78;
        sink_idle_pct = 22;
        run_random(150);

        // full rate, with one long receiver stall to back up the input
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        sink_hold     = LONG_HOLD;
        run_random(150);
        s_tvalid <= 1'b0;

        while (pixels_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_cnt == 0 && pixels_due.size() == 0) begin
            $display("line_rasterizer_core verification clean");
        end else begin
            $display("line_rasterizer_core verification failed");
        end
        $finish;
    end

endmodule

// File: sim.f
src/lr_pkg.sv
src/lr_front.sv
src/lr_cmd_fifo.sv
src/lr_back.sv
src/line_rasterizer_core.sv
bench/line_rasterizer_core_test.sv
